// ----- src/altint_pkg.sv -----
// Package for the arc-length table interpolator: widths, codes and word types.
// Depends on nothing; imported by arc_length_table_interpolator_core.
package altint_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int LO_W        = $clog2(TABLE_DEPTH + 1);

   localparam int ARC_W   = 32;
   localparam int PARAM_W = 17;
   localparam int KIND_W  = 3;
   localparam int COUNT_W = 11;
   localparam int SLOT_W  = 10;
   localparam int PROD_W  = ARC_W + PARAM_W;
   localparam int DIV_CNT_W = $clog2(PARAM_W + 1);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PARAM_LOW    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PARAM_HIGH   = 2'd3;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   localparam logic [KIND_W-1:0] KIND_BELOW  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ABOVE  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_EXACT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_INTERP = 3'd3;
   localparam logic [KIND_W-1:0] KIND_EQUAL  = 3'd4;

   localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RESET = 11'd2;
   localparam logic [PARAM_W-1:0] PARAM_HIGH_RESET   = 17'd65536;

   typedef struct packed {
      logic               action;
      logic [SLOT_W-1:0]  entry_index;
      logic [ARC_W-1:0]   arc_value;
      logic [PARAM_W-1:0] param_value;
   } req_word_type;

   typedef struct packed {
      logic [PARAM_W-1:0] param_out;
      logic [KIND_W-1:0]  result_kind;
   } rsp_word_type;

endpackage

// ----- src/arc_length_table_interpolator_core.sv -----
// Top level of the arc-length table interpolator: table memories, search, divider.
// Depends on altint_pkg.
//
// A write word loads one table entry. A query word that is clamped at zero or at
// the total length goes straight to the result. Any other query runs a binary
// search over the loaded entries, each step a memory read with its registered
// data, then the compare. After the search the bracketing pair is read, a
// multiply follows, and a restoring divider yields one quotient bit a cycle.
// The single read port of the table memories sets the search time. A new word
// is taken while a result still waits on the response side; the result of the
// next query waits until that slot is free.
module arc_length_table_interpolator_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  altint_pkg::req_word_type            req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output altint_pkg::rsp_word_type            rsp_word,
   input  logic                                csr_we,
   input  logic [altint_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [altint_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import altint_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_S_RD  = 4'd1;
   localparam logic [3:0] ST_S_CMP = 4'd2;
   localparam logic [3:0] ST_B_RD0 = 4'd3;
   localparam logic [3:0] ST_B_RD1 = 4'd4;
   localparam logic [3:0] ST_B_CAP = 4'd5;
   localparam logic [3:0] ST_B_EVL = 4'd6;
   localparam logic [3:0] ST_MUL   = 4'd7;
   localparam logic [3:0] ST_DIV   = 4'd8;
   localparam logic [3:0] ST_FIN   = 4'd9;
   localparam logic [3:0] ST_DONE  = 4'd10;

   logic [ARC_W-1:0]   arc_mem [TABLE_DEPTH];
   logic [PARAM_W-1:0] param_mem [TABLE_DEPTH];

   logic [COUNT_W-1:0] count_ff;
   logic [ARC_W-1:0]   total_ff;
   logic [PARAM_W-1:0] plow_ff;
   logic [PARAM_W-1:0] phigh_ff;

   logic [3:0]           state_ff, state_in;
   logic [ARC_W-1:0]     s_ff, s_in;
   logic [LO_W-1:0]      lo_ff, lo_in;
   logic [LO_W-1:0]      hip1_ff, hip1_in;
   logic [ADDR_W-1:0]    mid_ff, mid_in;
   logic [ARC_W-1:0]     sa_ff, sa_in, sb_ff, sb_in;
   logic [PARAM_W-1:0]   ta_ff, ta_in, tb_ff, tb_in;
   logic [ARC_W-1:0]     off_ff, off_in, span_ff, span_in;
   logic [PARAM_W-1:0]   dt_ff, dt_in;
   logic                 neg_ff, neg_in;
   logic [ARC_W-1:0]     rem_ff, rem_in;
   logic [PARAM_W-1:0]   quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [PARAM_W-1:0]   res_ff, res_in;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_word_ff, rsp_word_in;

   logic [ADDR_W-1:0]  rd_addr;
   logic [ARC_W-1:0]   arc_rd_ff;
   logic [PARAM_W-1:0] param_rd_ff;
   logic               mem_we;
   logic [LO_W-1:0]    n_val;
   logic [LO_W:0]      mid_sum;
   logic [PROD_W-1:0]  prod;
   logic [ARC_W:0]     trial;
   logic               req_take;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign mem_we    = req_take && (req_word.action == ACTION_WRITE) &&
                      (32'(req_word.entry_index) < 32'(TABLE_DEPTH));
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hip1_ff} - (LO_W + 1)'(1);
   assign prod      = PROD_W'(off_ff) * PROD_W'(dt_ff);
   assign trial     = {rem_ff, quo_ff[PARAM_W-1]};

   always_comb begin
      if (32'(count_ff) > 32'(TABLE_DEPTH)) begin
         n_val = LO_W'(TABLE_DEPTH);
      end else if (count_ff < COUNT_W'(2)) begin
         n_val = LO_W'(2);
      end else begin
         n_val = LO_W'(count_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      s_in         = s_ff;
      lo_in        = lo_ff;
      hip1_in      = hip1_ff;
      mid_in       = mid_ff;
      sa_in        = sa_ff;
      sb_in        = sb_ff;
      ta_in        = ta_ff;
      tb_in        = tb_ff;
      off_in       = off_ff;
      span_in      = span_ff;
      dt_in        = dt_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      kind_in      = kind_ff;
      rd_addr      = mid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && req_word.action == ACTION_QUERY) begin
               s_in    = req_word.arc_value;
               lo_in   = '0;
               hip1_in = n_val;
               if (req_word.arc_value == '0) begin
                  res_in   = plow_ff;
                  kind_in  = KIND_BELOW;
                  state_in = ST_DONE;
               end else if (req_word.arc_value >= total_ff) begin
                  res_in   = phigh_ff;
                  kind_in  = KIND_ABOVE;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_S_RD;
               end
            end
         end
         ST_S_RD: begin
            if (lo_ff < hip1_ff) begin
               mid_in   = ADDR_W'(mid_sum >> 1);
               rd_addr  = mid_in;
               state_in = ST_S_CMP;
            end else if (lo_ff == '0) begin
               res_in   = plow_ff;
               kind_in  = KIND_BELOW;
               state_in = ST_DONE;
            end else if (lo_ff >= n_val) begin
               res_in   = phigh_ff;
               kind_in  = KIND_ABOVE;
               state_in = ST_DONE;
            end else begin
               state_in = ST_B_RD0;
            end
         end
         ST_S_CMP: begin
            if (s_ff < arc_rd_ff) begin
               hip1_in  = LO_W'(mid_ff);
               state_in = ST_S_RD;
            end else if (s_ff > arc_rd_ff) begin
               lo_in    = LO_W'(mid_ff) + LO_W'(1);
               state_in = ST_S_RD;
            end else begin
               res_in   = param_rd_ff;
               kind_in  = KIND_EXACT;
               state_in = ST_DONE;
            end
         end
         ST_B_RD0: begin
            rd_addr  = ADDR_W'(lo_ff - LO_W'(1));
            state_in = ST_B_RD1;
         end
         ST_B_RD1: begin
            rd_addr  = ADDR_W'(lo_ff);
            sa_in    = arc_rd_ff;
            ta_in    = param_rd_ff;
            state_in = ST_B_CAP;
         end
         ST_B_CAP: begin
            sb_in    = arc_rd_ff;
            tb_in    = param_rd_ff;
            state_in = ST_B_EVL;
         end
         ST_B_EVL: begin
            off_in  = s_ff - sa_ff;
            span_in = sb_ff - sa_ff;
            if (tb_ff >= ta_ff) begin
               dt_in  = tb_ff - ta_ff;
               neg_in = 1'b0;
            end else begin
               dt_in  = ta_ff - tb_ff;
               neg_in = 1'b1;
            end
            if (sb_ff <= sa_ff || s_ff <= sa_ff || s_ff >= sb_ff) begin
               res_in   = ta_ff;
               kind_in  = KIND_EQUAL;
               state_in = ST_DONE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // The quotient is below dt, so the top bits of the product are
            // already smaller than the divisor and only the low bits iterate.
            rem_in   = prod[PROD_W-1:PARAM_W];
            quo_in   = prod[PARAM_W-1:0];
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (trial >= {1'b0, span_ff}) begin
               rem_in = ARC_W'(trial - {1'b0, span_ff});
               quo_in = {quo_ff[PARAM_W-2:0], 1'b1};
            end else begin
               rem_in = trial[ARC_W-1:0];
               quo_in = {quo_ff[PARAM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(PARAM_W - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            res_in   = neg_ff ? (ta_ff - quo_ff) : (ta_ff + quo_ff);
            kind_in  = KIND_INTERP;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_word_in.param_out   = res_ff;
               rsp_word_in.result_kind = kind_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         arc_mem[ADDR_W'(req_word.entry_index)]   <= req_word.arc_value;
         param_mem[ADDR_W'(req_word.entry_index)] <= req_word.param_value;
      end
      arc_rd_ff   <= arc_mem[rd_addr];
      param_rd_ff <= param_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= SAMPLE_COUNT_RESET;
         total_ff <= '0;
         plow_ff  <= '0;
         phigh_ff <= PARAM_HIGH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SAMPLE_COUNT: count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_TOTAL_LENGTH: total_ff <= csr_wdata[ARC_W-1:0];
            CSR_PARAM_LOW:    plow_ff  <= csr_wdata[PARAM_W-1:0];
            CSR_PARAM_HIGH:   phigh_ff <= csr_wdata[PARAM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff        <= s_in;
      lo_ff       <= lo_in;
      hip1_ff     <= hip1_in;
      mid_ff      <= mid_in;
      sa_ff       <= sa_in;
      sb_ff       <= sb_in;
      ta_ff       <= ta_in;
      tb_ff       <= tb_in;
      off_ff      <= off_in;
      span_ff     <= span_in;
      dt_ff       <= dt_in;
      neg_ff      <= neg_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      res_ff      <= res_in;
      kind_ff     <= kind_in;
      rsp_word_ff <= rsp_word_in;
   end

   a_cmp_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_S_CMP |-> lo_ff < hip1_ff)
      else $error("search compare entered with an empty range");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> cnt_ff < DIV_CNT_W'(PARAM_W))
      else $error("divider ran past its quotient width");

   a_quo_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN |-> quo_ff <= dt_ff)
      else $error("interpolation step exceeds the parameter span");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && rsp_valid_ff && !rsp_ready |=> state_ff == ST_DONE)
      else $error("finished result left while the response word was stalled");

endmodule
